@@ hw/rtl/cbnp_pkg.sv @@
`default_nettype none
package cbnp_pkg;

   localparam int NUM_SYMBOLS = 16;
   localparam int MAX_DIGITS  = 16;
   localparam int SYM_WIDTH   = 8;
   localparam int BASE_WIDTH  = 5;
   localparam int DIGIT_WIDTH = 4;
   localparam int VALUE_WIDTH = 32;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [SYM_WIDTH-1:0] CHAR_TAB   = 8'd9;
   localparam logic [SYM_WIDTH-1:0] CHAR_CR    = 8'd13;
   localparam logic [SYM_WIDTH-1:0] CHAR_SPACE = 8'd32;
   localparam logic [SYM_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYM_WIDTH-1:0] CHAR_NUL   = 8'h00;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ALPHABET_LOW  = 2'd0,
      CSR_ALPHABET_HIGH = 2'd1,
      CSR_BASE_LENGTH   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_SPACE = 4'b0001,
      PH_SIGN  = 4'b0010,
      PH_DIGIT = 4'b0100,
      PH_STOP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [NUM_SYMBOLS-1:0][SYM_WIDTH-1:0] symbols;
      logic [BASE_WIDTH-1:0]                 base_length;
      logic                                  alphabet_ok;
   } csr_type;

   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic                   is_space;
      logic                   is_plus;
      logic                   is_minus;
      logic                   is_digit;
      logic [DIGIT_WIDTH-1:0] digit;
   } match_type;

   function automatic logic is_space_char(input logic [SYM_WIDTH-1:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

   function automatic logic [BASE_WIDTH-1:0] used_count(input logic [BASE_WIDTH-1:0] b);
      logic [BASE_WIDTH-1:0] n;
      n = b;
      if (n > BASE_WIDTH'(NUM_SYMBOLS)) begin
         n = BASE_WIDTH'(NUM_SYMBOLS);
      end
      if (n > BASE_WIDTH'(MAX_DIGITS)) begin
         n = BASE_WIDTH'(MAX_DIGITS);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/custom_base_number_parser.sv @@
`default_nettype none
// A result is registered once the transaction carrying last leaves the match stage.
// One character per cycle unless a last one waits on a stalled result; digit match is
// registered in a first stage, the multiply-add and sign handling update the parser
// state in the second. Reset (synchronous, active high) clears the registers, the
// parser state and both pipeline valids; the alphabet is invalid until configured.
module custom_base_number_parser (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [cbnp_pkg::SYM_WIDTH-1:0]        req_ch,
   input  wire logic                                  req_last,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [cbnp_pkg::VALUE_WIDTH-1:0]    rsp_value,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cbnp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [cbnp_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import cbnp_pkg::*;

   csr_type   csr;
   match_type stage;
   logic      stage_ready;

   assign req_stall = !stage_ready;

   cbnp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_out   (csr)
   );

   cbnp_match u_match (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ch      (req_ch),
      .req_last    (req_last),
      .stage_ready (stage_ready),
      .csr_in      (csr),
      .stage_out   (stage)
   );

   cbnp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage_in    (stage),
      .csr_in      (csr),
      .stage_ready (stage_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value)
   );

endmodule
`default_nettype wire

@@ hw/rtl/cbnp_csr.sv @@
`default_nettype none
module cbnp_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cbnp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cbnp_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output cbnp_pkg::csr_type                         csr_out
);
   import cbnp_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] alpha_low_ff, alpha_low_in;
   logic [CSR_DATA_WIDTH-1:0] alpha_high_ff, alpha_high_in;
   logic [BASE_WIDTH-1:0]     base_ff, base_in;
   logic                      ok_ff, ok_in;
   logic [NUM_SYMBOLS-1:0][SYM_WIDTH-1:0] syms;

   assign csr_ready = 1'b1;
   assign syms = {alpha_high_ff, alpha_low_ff};

   always_comb begin
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      base_in       = base_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ALPHABET_LOW:  alpha_low_in  = csr_data;
            CSR_ALPHABET_HIGH: alpha_high_in = csr_data;
            CSR_BASE_LENGTH:   base_in       = csr_data[BASE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ok_in = (base_ff >= BASE_WIDTH'(2)) && (base_ff <= BASE_WIDTH'(NUM_SYMBOLS))
              && (base_ff <= BASE_WIDTH'(MAX_DIGITS));
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if (BASE_WIDTH'(i) < base_ff) begin
            if (is_space_char(syms[i]) || (syms[i] == CHAR_PLUS) ||
                (syms[i] == CHAR_MINUS) || (syms[i] == CHAR_NUL)) begin
               ok_in = 1'b0;
            end
            for (int j = 0; j < i; j++) begin
               if (syms[j] == syms[i]) begin
                  ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         base_ff       <= '0;
         ok_ff         <= 1'b0;
      end else begin
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
         base_ff       <= base_in;
         ok_ff         <= ok_in;
      end
   end

   assign csr_out.symbols     = syms;
   assign csr_out.base_length = base_ff;
   assign csr_out.alphabet_ok = ok_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cbnp_match.sv @@
`default_nettype none
module cbnp_match (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic [cbnp_pkg::SYM_WIDTH-1:0] req_ch,
   input  wire logic                           req_last,
   input  wire logic                           stage_ready,
   input  wire cbnp_pkg::csr_type              csr_in,
   output cbnp_pkg::match_type                 stage_out
);
   import cbnp_pkg::*;

   match_type             stage_ff, stage_in;
   logic [BASE_WIDTH-1:0] n_used;
   logic [NUM_SYMBOLS-1:0] hit;
   logic [DIGIT_WIDTH-1:0] idx;

   assign n_used = used_count(csr_in.base_length);

   always_comb begin
      idx = '0;
      for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
         hit[i] = (BASE_WIDTH'(i) < n_used) && (csr_in.symbols[i] == req_ch);
         if (hit[i]) begin
            idx = DIGIT_WIDTH'(i);
         end
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (stage_ready) begin
         stage_in.valid    = req_valid;
         stage_in.last     = req_last;
         stage_in.is_space = is_space_char(req_ch);
         stage_in.is_plus  = (req_ch == CHAR_PLUS);
         stage_in.is_minus = (req_ch == CHAR_MINUS);
         stage_in.is_digit = (|hit) && (req_ch != CHAR_NUL);
         stage_in.digit    = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.last     <= stage_in.last;
      stage_ff.is_space <= stage_in.is_space;
      stage_ff.is_plus  <= stage_in.is_plus;
      stage_ff.is_minus <= stage_in.is_minus;
      stage_ff.is_digit <= stage_in.is_digit;
      stage_ff.digit    <= stage_in.digit;
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cbnp_core.sv @@
`default_nettype none
module cbnp_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cbnp_pkg::match_type                     stage_in,
   input  wire cbnp_pkg::csr_type                       csr_in,
   output logic                                         stage_ready,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [cbnp_pkg::VALUE_WIDTH-1:0]      rsp_value
);
   import cbnp_pkg::*;

   phase_type               phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic                    fire;
   phase_type               ph;
   logic                    neg;
   logic [VALUE_WIDTH-1:0]  acc;

   assign fire = stage_in.valid && !(stage_in.last && rsp_valid_ff && rsp_stall);
   assign stage_ready = !stage_in.valid || fire;

   always_comb begin
      ph  = phase_ff;
      neg = neg_ff;
      acc = acc_ff;
      if ((ph == PH_SPACE) && !stage_in.is_space) begin
         ph = PH_SIGN;
      end
      if (ph == PH_SIGN) begin
         if (stage_in.is_minus) begin
            neg = !neg;
         end else if (!stage_in.is_plus) begin
            ph = PH_DIGIT;
         end
      end
      if (ph == PH_DIGIT) begin
         if (!stage_in.is_digit) begin
            ph = PH_STOP;
         end else begin
            acc = acc_ff * VALUE_WIDTH'(csr_in.base_length)
                  + VALUE_WIDTH'(stage_in.digit);
         end
      end

      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      if (fire) begin
         if (stage_in.last) begin
            phase_in     = PH_SPACE;
            neg_in       = 1'b0;
            acc_in       = '0;
            rsp_valid_in = 1'b1;
            if (!csr_in.alphabet_ok) begin
               rsp_value_in = '0;
            end else if (neg) begin
               rsp_value_in = '0 - acc;
            end else begin
               rsp_value_in = acc;
            end
         end else begin
            phase_in = ph;
            neg_in   = neg;
            acc_in   = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = $signed(rsp_value_ff);

endmodule
`default_nettype wire

@@ tb/custom_base_number_parser_checker.sv @@
`timescale 1ns / 1ps
module custom_base_number_parser_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_stall,
   input  wire logic [cbnp_pkg::SYM_WIDTH-1:0]        req_ch,
   input  wire logic                                  req_last,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic signed [cbnp_pkg::VALUE_WIDTH-1:0] rsp_value,
   input  wire logic                                  csr_valid,
   input  wire logic                                  csr_ready,
   input  wire logic [cbnp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [cbnp_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                         errors,
   output int                                         pending
);
   import cbnp_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] symbols_low;
   logic [CSR_DATA_WIDTH-1:0] symbols_high;
   logic [BASE_WIDTH-1:0]     base_reg;
   phase_type                 parse_phase;
   logic                      sign_flip;
   logic [VALUE_WIDTH-1:0]    total;
   logic [VALUE_WIDTH-1:0]    parsed_values [$];

   initial begin
      errors = 0;
      pending = 0;
   end

   function automatic logic [SYM_WIDTH-1:0] symbol_of(input int k);
      if (k < 8) begin
         return symbols_low[8*k +: 8];
      end
      return symbols_high[8*(k-8) +: 8];
   endfunction

   function automatic bit blank(input logic [SYM_WIDTH-1:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

   function automatic int symbols_in_use();
      int n;
      n = base_reg;
      if (n > NUM_SYMBOLS) begin
         n = NUM_SYMBOLS;
      end
      if (n > MAX_DIGITS) begin
         n = MAX_DIGITS;
      end
      return n;
   endfunction

   function automatic int digit_of(input logic [SYM_WIDTH-1:0] c);
      int k;
      if (c == CHAR_NUL) begin
         return -1;
      end
      for (k = 0; k < symbols_in_use(); k++) begin
         if (symbol_of(k) == c) begin
            return k;
         end
      end
      return -1;
   endfunction

   function automatic bit alphabet_usable();
      int n, i, j;
      logic [SYM_WIDTH-1:0] s;
      n = base_reg;
      if ((n < 2) || (n > NUM_SYMBOLS) || (n > MAX_DIGITS)) begin
         return 0;
      end
      for (i = 0; i < n; i++) begin
         s = symbol_of(i);
         if (blank(s) || (s == CHAR_PLUS) || (s == CHAR_MINUS) || (s == CHAR_NUL)) begin
            return 0;
         end
         for (j = 0; j < i; j++) begin
            if (symbol_of(j) == s) begin
               return 0;
            end
         end
      end
      return 1;
   endfunction

   task automatic parse_char(input logic [SYM_WIDTH-1:0] c, input logic fin);
      int d;
      logic [VALUE_WIDTH-1:0] v;
      if ((parse_phase == PH_SPACE) && !blank(c)) begin
         parse_phase = PH_SIGN;
      end
      if (parse_phase == PH_SIGN) begin
         if (c == CHAR_MINUS) begin
            sign_flip = ~sign_flip;
         end else if (c != CHAR_PLUS) begin
            parse_phase = PH_DIGIT;
         end
      end
      if (parse_phase == PH_DIGIT) begin
         d = digit_of(c);
         if (d < 0) begin
            parse_phase = PH_STOP;
         end else begin
            total = total * VALUE_WIDTH'(base_reg) + VALUE_WIDTH'(d);
         end
      end
      if (fin) begin
         v = '0;
         if (alphabet_usable()) begin
            v = sign_flip ? -total : total;
         end
         parsed_values.push_back(v);
         parse_phase = PH_SPACE;
         sign_flip = 1'b0;
         total = '0;
      end
   endtask

   always @(posedge clock) begin
      logic [VALUE_WIDTH-1:0] want;
      if (reset) begin
         symbols_low = '0;
         symbols_high = '0;
         base_reg = '0;
         parse_phase = PH_SPACE;
         sign_flip = 1'b0;
         total = '0;
         parsed_values.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALPHABET_LOW: symbols_low = csr_data;
               CSR_ALPHABET_HIGH: symbols_high = csr_data;
               CSR_BASE_LENGTH: base_reg = csr_data[BASE_WIDTH-1:0];
               default: ;
            endcase
         end
         // result transaction
         if (rsp_valid && !rsp_stall) begin
            if (parsed_values.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected value %0d", $time, rsp_value);
               end
            end else begin
               want = parsed_values.pop_front();
               if (rsp_value !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: value mismatch, expected %0d got %0d", $time,
                              $signed(want), rsp_value);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_char(req_ch, req_last);
         end
      end
      pending = parsed_values.size();
   end

endmodule

@@ tb/custom_base_number_parser_tb.sv @@
`timescale 1ns / 1ps
module custom_base_number_parser_tb;
   import cbnp_pkg::*;

   localparam int TEXT_BYTES    = 1200;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRESSURE_HOLD = 300;
   localparam int DRAIN_CYCLES  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [SYM_WIDTH-1:0]       req_ch;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [VALUE_WIDTH-1:0] rsp_value;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   int errors;
   int pending;
   int bytes_sent;
   int cycles;
   bit calm;
   bit hold_request;
   bit pressured;

   logic [SYM_WIDTH-1:0]  alphabet [NUM_SYMBOLS];
   logic [BASE_WIDTH-1:0] radix;
   logic [SYM_WIDTH-1:0]  text [$];

   custom_base_number_parser i_dut (.*);

   custom_base_number_parser_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("custom_base_number_parser verification failed");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 50);
   endfunction

   initial begin
      int run;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (PRESSURE_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (calm || ($urandom_range(0, 2) != 0)) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            run = idle_cycles();
            if (run == 0) begin
               run = 1;
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   function automatic logic [SYM_WIDTH-1:0] blank_char();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CHAR_SPACE : CHAR_TAB + SYM_WIDTH'(r);
   endfunction

   function automatic logic [SYM_WIDTH-1:0] forbidden_char();
      case ($urandom_range(0, 4))
         0: return CHAR_NUL;
         1: return CHAR_PLUS;
         2: return CHAR_MINUS;
         default: return blank_char();
      endcase
   endfunction

   task automatic push_char(input logic [SYM_WIDTH-1:0] c, input logic fin);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_last <= fin;
      // transaction taken when valid and not stalled
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input bit open);
      int k;
      for (k = 0; k < text.size(); k++) begin
         push_char(text[k], !open && (k == text.size() - 1));
      end
   endtask

   task automatic send_str(input string s);
      int k;
      text.delete();
      for (k = 0; k < s.len(); k++) begin
         text.push_back(s[k]);
      end
      send_text(1'b0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure();
      int k;
      logic [CSR_DATA_WIDTH-1:0] lo, hi, len;
      for (k = 0; k < 8; k++) begin
         lo[8*k +: 8] = alphabet[k];
         hi[8*k +: 8] = alphabet[k+8];
      end
      len = '0;
      if ($urandom_range(0, 3) == 0) begin
         len = {$urandom, $urandom};
      end
      len[BASE_WIDTH-1:0] = radix;
      write_reg(CSR_ALPHABET_LOW, lo);
      write_reg(CSR_ALPHABET_HIGH, hi);
      if ($urandom_range(0, 4) == 0) begin
         write_reg(CSR_UNMAPPED, {$urandom, $urandom});
      end
      write_reg(CSR_BASE_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   task automatic set_chars(input string s);
      int k;
      for (k = 0; k < NUM_SYMBOLS; k++) begin
         alphabet[k] = (k < s.len()) ? s[k] : SYM_WIDTH'($urandom);
      end
      radix = BASE_WIDTH'(s.len());
   endtask

   task automatic fill_distinct();
      int k, j;
      logic [SYM_WIDTH-1:0] c;
      bit clash;
      for (k = 0; k < NUM_SYMBOLS; k++) begin
         do begin
            c = SYM_WIDTH'($urandom);
            clash = (c == CHAR_NUL) || (c == CHAR_PLUS) || (c == CHAR_MINUS) ||
                    (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
            for (j = 0; j < k; j++) begin
               if (alphabet[j] == c) begin
                  clash = 1'b1;
               end
            end
         end while (clash);
         alphabet[k] = c;
      end
   endtask

   task automatic pick_alphabet();
      int n, i, j, k;
      n = $urandom_range(2, NUM_SYMBOLS);
      case ($urandom_range(0, 8))
         0: set_chars("0123456789");
         1: set_chars("0123456789abcdef");
         2: set_chars("01");
         3: begin
            fill_distinct();
            radix = BASE_WIDTH'(n);
         end
         4: begin
            fill_distinct();
            radix = BASE_WIDTH'(NUM_SYMBOLS);
         end
         5: begin
            fill_distinct();
            radix = BASE_WIDTH'(n);
            alphabet[$urandom_range(0, n - 1)] = forbidden_char();
         end
         6: begin
            fill_distinct();
            radix = BASE_WIDTH'(n);
            j = $urandom_range(1, n - 1);
            i = $urandom_range(0, j - 1);
            alphabet[j] = alphabet[i];
         end
         7: begin
            fill_distinct();
            if ($urandom_range(0, 1) == 0) begin
               radix = BASE_WIDTH'($urandom_range(0, 1));
            end else begin
               radix = BASE_WIDTH'($urandom_range(NUM_SYMBOLS + 1, (1 << BASE_WIDTH) - 1));
            end
         end
         default: begin
            for (k = 0; k < NUM_SYMBOLS; k++) begin
               alphabet[k] = SYM_WIDTH'($urandom);
            end
            radix = BASE_WIDTH'($urandom);
         end
      endcase
   endtask

   function automatic logic [SYM_WIDTH-1:0] some_digit();
      int n;
      n = (radix > NUM_SYMBOLS) ? NUM_SYMBOLS : radix;
      if (n == 0) begin
         return SYM_WIDTH'($urandom);
      end
      return alphabet[$urandom_range(0, n - 1)];
   endfunction

   task automatic make_number();
      int nd;
      text.delete();
      repeat ($urandom_range(0, 3)) text.push_back(blank_char());
      repeat ($urandom_range(0, 3)) begin
         text.push_back(($urandom_range(0, 1) == 0) ? CHAR_MINUS : CHAR_PLUS);
      end
      nd = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      repeat (nd) text.push_back(some_digit());
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 3))
            0: text.push_back(CHAR_NUL);
            1: text.push_back(blank_char());
            2: text.push_back(CHAR_MINUS);
            default: text.push_back(SYM_WIDTH'($urandom));
         endcase
         repeat ($urandom_range(0, 3)) text.push_back(SYM_WIDTH'($urandom));
      end
      if (text.size() == 0) begin
         text.push_back(blank_char());
      end
   endtask

   task automatic make_noise();
      text.delete();
      repeat ($urandom_range(1, 10)) begin
         case ($urandom_range(0, 4))
            0: text.push_back(blank_char());
            1: text.push_back(($urandom_range(0, 1) == 0) ? CHAR_MINUS : CHAR_PLUS);
            2: text.push_back(some_digit());
            default: text.push_back(SYM_WIDTH'($urandom));
         endcase
      end
   endtask

   initial begin
      int budget, start, k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch = '0;
      req_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ALPHABET_LOW;
      csr_data = '0;
      calm = 1'b0;
      hold_request = 1'b0;
      pressured = 1'b0;
      bytes_sent = 0;
      radix = '0;
      for (k = 0; k < NUM_SYMBOLS; k++) begin
         alphabet[k] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers at reset values: alphabet invalid, value reads zero
      push_char(8'hFF, 1'b1);
      settle();
      set_chars("01");
      configure();
      send_str("\t-+-101");
      text = '{CHAR_MINUS, 8'h31, CHAR_NUL, 8'h31};
      send_text(1'b0);
      settle();
      set_chars("0123456789abcdef");
      configure();
      send_str("-fffffffff");
      settle();
      set_chars("a+");
      configure();
      send_str("a");

      while (bytes_sent < TEXT_BYTES) begin
         settle();
         pick_alphabet();
         configure();
         calm = ($urandom_range(0, 5) == 0);
         if (!pressured && (bytes_sent >= TEXT_BYTES / 3)) begin
            pressured = 1'b1;
            calm = 1'b1;
            hold_request = 1'b1;
         end
         budget = $urandom_range(40, 120);
         start = bytes_sent;
         while (bytes_sent - start < budget) begin
            if ($urandom_range(0, 6) == 0) begin
               make_noise();
            end else begin
               make_number();
            end
            send_text(1'b0);
         end
         // leave a string open across the next register update
         if ($urandom_range(0, 4) == 0) begin
            make_number();
            send_text(1'b1);
         end
      end
      settle();

      if (errors == 0) begin
         $display("custom_base_number_parser verification clean");
      end else begin
         $display("custom_base_number_parser verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/cbnp_pkg.sv
hw/rtl/cbnp_csr.sv
hw/rtl/cbnp_match.sv
hw/rtl/cbnp_core.sv
hw/rtl/custom_base_number_parser.sv
tb/custom_base_number_parser_checker.sv
tb/custom_base_number_parser_tb.sv
